FILE: hdl/spsg_pkg.sv
// shared types and constants for the pid step generator
// no dependencies
package spsg_pkg;

  localparam int unsigned FRACTION_BITS_DEF  = 16;
  localparam int unsigned POSITION_WIDTH_DEF = 32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_VMAX   = 3'd4,
    REG_AMAX   = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_INT_MUL,
    ST_INT_ADD,
    ST_DIV,
    ST_DER_FIX,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_SUM,
    ST_SLEW,
    ST_FRAC_MUL,
    ST_FRAC_ADD,
    ST_STEP,
    ST_DONE
  } exec_state_e;

  // one queued request between front and back
  typedef struct packed {
    logic               clear;
    logic signed [47:0] ref_pos;
    logic signed [31:0] meas_pos;
  } req_t;

  // result item
  typedef struct packed {
    logic               step_pulse;
    logic               direction;
    logic signed [31:0] commanded_position;
    logic signed [47:0] velocity_command;
  } res_t;

endpackage

FILE: hdl/spsg_front.sv
// front part: request queue between the input port and the execution unit
// depends on spsg_pkg
module spsg_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  spsg_pkg::req_t  req_i,
  output logic            req_valid_o,
  input  logic            req_take_i,
  output spsg_pkg::req_t  req_o
);

  spsg_pkg::req_t mem_q [2];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic       do_push, do_pop;

  assign full_o      = (wr_q[0] == rd_q[0]) && (wr_q[1] != rd_q[1]);
  assign req_valid_o = (wr_q != rd_q);
  assign do_push     = push_i && !full_o;
  assign do_pop      = req_take_i && req_valid_o;
  assign wr_d        = wr_q + 2'(do_push);
  assign rd_d        = rd_q + 2'(do_pop);
  assign req_o       = mem_q[rd_q[0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q[0]] <= req_i;
    end
  end

endmodule

FILE: hdl/spsg_divider.sv
// restoring divider: magnitude << fraction bits over a 16 bit period
// depends on nothing but its parameters
module spsg_divider #(
  parameter int unsigned NUM_W = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [15:0]      den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [16:0]      rem_q, rem_d;
  logic [15:0]      den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [16:0]      trial;
  logic [17:0]      diff;

  assign trial = {rem_q[15:0], quo_q[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[16:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: hdl/spsg_back.sv
// back part: sequenced pid, slew limiter and step accumulator
// depends on spsg_pkg and spsg_divider
module spsg_back #(
  parameter int unsigned FRACTION_BITS  = spsg_pkg::FRACTION_BITS_DEF,
  parameter int unsigned POSITION_WIDTH = spsg_pkg::POSITION_WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_take_o,
  input  spsg_pkg::req_t req_i,
  input  logic [15:0]    period_i,
  input  logic [31:0]    kp_i,
  input  logic [31:0]    ki_i,
  input  logic [31:0]    kd_i,
  input  logic [31:0]    vmax_i,
  input  logic [31:0]    amax_i,
  output logic           res_valid_o,
  input  logic           res_take_i,
  output spsg_pkg::res_t res_o
);

  localparam logic signed [63:0] ONE_Q    = 64'sd1 <<< FRACTION_BITS;
  localparam logic signed [63:0] E48_MAX  = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [63:0] E48_MIN  = -(64'sd1 <<< 47);
  localparam logic [63:0]        TERM_LIM = 64'd1 << 61;
  localparam logic [63:0]        WIDE_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned        DIV_W    = 64 + FRACTION_BITS;

  spsg_pkg::exec_state_e state_q, state_d;

  logic signed [63:0] integ_q, prev_q, vel_q, frac_q;
  logic [POSITION_WIDTH-1:0] steps_q;
  logic               dir_q, step_q;
  logic signed [63:0] err_q, der_q, raw_q, tmp_q;
  logic [15:0]        dt_q;
  logic               res_valid_q, res_valid_d;
  spsg_pkg::res_t     res_q;

  // shared pair of 32x32 multipliers over two halves of a magnitude, products registered
  logic [63:0]        mul_mag;
  logic [31:0]        mul_g;
  logic [63:0]        mul_lim, mul_lim_q;
  logic               mul_neg, mul_neg_q;
  logic [63:0]        p_lo, p_hi;
  logic signed [63:0] mul_res;

  // divider for the derivative term
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_quo;
  logic [63:0]      div_mag;

  logic signed [64:0] diff65, sum65;
  logic signed [63:0] err_full, maxdv, vmax_s, amax_s, d_val, new_frac;
  logic [63:0]        der_mag;
  logic [47:0]        ap;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  spsg_divider #(.NUM_W(DIV_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({div_mag, {FRACTION_BITS{1'b0}}}),
    .den_i   (dt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign vmax_s = (vmax_i < 32'(ONE_Q)) ? ONE_Q : 64'(vmax_i);
  assign amax_s = (amax_i < 32'(ONE_Q)) ? ONE_Q : 64'(amax_i);
  assign ap     = 48'(amax_s[31:0]) * 48'(dt_q);
  assign maxdv  = 64'(ap >> FRACTION_BITS);
  assign err_full = 64'(req_i.ref_pos) - (64'(req_i.meas_pos) <<< FRACTION_BITS);
  assign sum65  = 65'(integ_q) + 65'(mul_res);
  assign diff65 = 65'(err_q) - 65'(prev_q);
  assign d_val  = clamp(raw_q - vel_q, -maxdv, maxdv);
  assign new_frac = clamp(frac_q + mul_res, E48_MIN, E48_MAX);
  assign der_mag = (div_quo[DIV_W-1:64] != '0 || div_quo[63:0] > TERM_LIM) ?
                   TERM_LIM : div_quo[63:0];
  assign div_mag = mag64(err_q - prev_q);

  always_comb begin
    state_d    = state_q;
    req_take_o = 1'b0;
    div_start  = 1'b0;
    mul_mag = '0; mul_g = '0; mul_lim = WIDE_LIM; mul_neg = 1'b0;
    case (state_q)
      spsg_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          state_d = req_i.clear ? spsg_pkg::ST_DONE : spsg_pkg::ST_ERR;
        end
      end
      spsg_pkg::ST_ERR:     state_d = spsg_pkg::ST_INT_MUL;
      spsg_pkg::ST_INT_MUL: begin
        mul_mag = mag64(err_q); mul_g = 32'(dt_q); mul_neg = err_q[63];
        state_d = spsg_pkg::ST_INT_ADD;
      end
      spsg_pkg::ST_INT_ADD: begin
        div_start = 1'b1;
        state_d = spsg_pkg::ST_DIV;
      end
      spsg_pkg::ST_DIV: begin
        if (div_done) state_d = spsg_pkg::ST_DER_FIX;
      end
      spsg_pkg::ST_DER_FIX: state_d = spsg_pkg::ST_P_MUL;
      spsg_pkg::ST_P_MUL: begin
        mul_mag = mag64(err_q); mul_g = kp_i; mul_lim = TERM_LIM; mul_neg = err_q[63];
        state_d = spsg_pkg::ST_I_MUL;
      end
      spsg_pkg::ST_I_MUL: begin
        mul_mag = mag64(integ_q); mul_g = ki_i; mul_lim = TERM_LIM;
        mul_neg = integ_q[63];
        state_d = spsg_pkg::ST_D_MUL;
      end
      spsg_pkg::ST_D_MUL: begin
        mul_mag = mag64(der_q); mul_g = kd_i; mul_lim = TERM_LIM; mul_neg = der_q[63];
        state_d = spsg_pkg::ST_SUM;
      end
      spsg_pkg::ST_SUM:  state_d = spsg_pkg::ST_SLEW;
      spsg_pkg::ST_SLEW: state_d = spsg_pkg::ST_FRAC_MUL;
      spsg_pkg::ST_FRAC_MUL: begin
        mul_mag = mag64(vel_q); mul_g = 32'(dt_q); mul_neg = vel_q[63];
        state_d = spsg_pkg::ST_FRAC_ADD;
      end
      spsg_pkg::ST_FRAC_ADD: state_d = spsg_pkg::ST_STEP;
      spsg_pkg::ST_STEP:     state_d = spsg_pkg::ST_DONE;
      spsg_pkg::ST_DONE: begin
        // hand over once the result register is free or being emptied
        if (!res_valid_q || res_take_i) begin
          req_take_o = 1'b1;
          state_d = spsg_pkg::ST_IDLE;
        end
      end
      default: state_d = spsg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_take_i) res_valid_d = 1'b0;
    if (req_take_o) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    p_lo      <= 64'(mul_mag[31:0]) * 64'(mul_g);
    p_hi      <= 64'(mul_mag[63:32]) * 64'(mul_g);
    mul_neg_q <= mul_neg;
    mul_lim_q <= mul_lim;
  end

  // scaled product, valid in the cycle after the multiply state
  always_comb begin
    mul_res = '0;
    if (p_hi > (mul_lim_q >> (32 - FRACTION_BITS))) begin
      mul_res = mul_lim_q;
    end else begin
      mul_res = (p_hi << (32 - FRACTION_BITS)) + (p_lo >> FRACTION_BITS);
      if (mul_res > mul_lim_q) mul_res = mul_lim_q;
    end
    if (mul_neg_q) mul_res = -mul_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spsg_pkg::ST_IDLE;
      integ_q     <= '0;
      prev_q      <= '0;
      vel_q       <= '0;
      frac_q      <= '0;
      steps_q     <= '0;
      dir_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      case (state_q)
        spsg_pkg::ST_INT_ADD: begin
          // integral product is ready here
          if (sum65[64] != sum65[63]) begin
            integ_q <= sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
          end else begin
            integ_q <= sum65[63:0];
          end
        end
        spsg_pkg::ST_DER_FIX: prev_q <= err_q;
        spsg_pkg::ST_SLEW:    vel_q  <= vel_q + d_val;
        spsg_pkg::ST_FRAC_ADD: frac_q <= new_frac;
        spsg_pkg::ST_STEP: begin
          if (frac_q >= ONE_Q) begin
            dir_q <= 1'b0; frac_q <= frac_q - ONE_Q; steps_q <= steps_q + 1'b1;
          end else if (frac_q <= -ONE_Q) begin
            dir_q <= 1'b1; frac_q <= frac_q + ONE_Q; steps_q <= steps_q - 1'b1;
          end
        end
        spsg_pkg::ST_DONE: begin
          if (req_take_o && req_i.clear) begin
            integ_q <= '0; prev_q <= '0; vel_q <= '0; frac_q <= '0;
            steps_q <= '0; dir_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      spsg_pkg::ST_ERR: begin
        err_q <= clamp(err_full, E48_MIN, E48_MAX);
        dt_q  <= (period_i == '0) ? 16'd1 : period_i;
        step_q <= 1'b0;
      end
      spsg_pkg::ST_DER_FIX:  der_q <= diff65[64] ? -$signed(der_mag) : $signed(der_mag);
      spsg_pkg::ST_I_MUL:    tmp_q <= mul_res;
      spsg_pkg::ST_D_MUL:    tmp_q <= tmp_q + mul_res;
      spsg_pkg::ST_SUM:      raw_q <= clamp(tmp_q + mul_res, -vmax_s, vmax_s);
      spsg_pkg::ST_STEP:     step_q <= (frac_q >= ONE_Q) || (frac_q <= -ONE_Q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_take_o) begin
      if (req_i.clear) begin
        res_q <= '0;
      end else begin
        res_q.step_pulse         <= step_q;
        res_q.direction          <= dir_q;
        res_q.commanded_position <= 32'($signed(steps_q));
        res_q.velocity_command   <= vel_q[47:0];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/stepper_pid_step_generator.sv
// top level of the pid step generator, with its port checker bound in
// depends on spsg_pkg, spsg_front, spsg_back
//
// one request per control tick: a tick request runs from the head of the two-entry
// request queue through the bit serial divider for the derivative term to its result
// on the result ports; a clear request goes from idle straight to the final state;
// the back part works one request at a time, taking the next only once it is done;
// the result register lets the back part run the next request while a result waits,
// and the back part only holds in its final state if the previous result is still
// unread; registers are sampled live, so write them only while nothing is in flight
module stepper_pid_step_generator #(
  parameter int unsigned FRACTION_BITS  = spsg_pkg::FRACTION_BITS_DEF,
  parameter int unsigned POSITION_WIDTH = spsg_pkg::POSITION_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic                                command_i,
  input  logic signed [47:0]                  reference_position_i,
  input  logic signed [31:0]                  measured_position_i,
  output logic                                empty,
  input  logic                                pop,
  output logic                                step_pulse_o,
  output logic                                direction_o,
  output logic signed [31:0]                  commanded_position_o,
  output logic signed [47:0]                  velocity_command_o,
  input  logic                                cfg_we_i,
  input  logic [spsg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [spsg_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  logic [15:0] period_q;
  logic [31:0] kp_q, ki_q, kd_q, vmax_q, amax_q;
  spsg_pkg::req_t req_in, req_q;
  spsg_pkg::res_t res;
  logic req_valid, req_take, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 16'd66;
      kp_q <= '0; ki_q <= '0; kd_q <= '0;
      vmax_q <= 32'd65536000; amax_q <= 32'd65536000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spsg_pkg::REG_PERIOD: period_q <= cfg_data_i[15:0];
        spsg_pkg::REG_KP:     kp_q     <= cfg_data_i;
        spsg_pkg::REG_KI:     ki_q     <= cfg_data_i;
        spsg_pkg::REG_KD:     kd_q     <= cfg_data_i;
        spsg_pkg::REG_VMAX:   vmax_q   <= cfg_data_i;
        spsg_pkg::REG_AMAX:   amax_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req_in = '{clear: command_i, ref_pos: reference_position_i,
                    meas_pos: measured_position_i};

  spsg_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .req_i(req_in),
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req_q)
  );

  spsg_back #(.FRACTION_BITS(FRACTION_BITS), .POSITION_WIDTH(POSITION_WIDTH)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req_q),
    .period_i(period_q), .kp_i(kp_q), .ki_i(ki_q), .kd_i(kd_q),
    .vmax_i(vmax_q), .amax_i(amax_q),
    .res_valid_o(res_valid), .res_take_i(pop && !empty), .res_o(res)
  );

  assign empty                = !res_valid;
  assign step_pulse_o         = res.step_pulse;
  assign direction_o          = res.direction;
  assign commanded_position_o = res.commanded_position;
  assign velocity_command_o   = res.velocity_command;

endmodule

// port checker: handshake behaviour seen on the top level
module spsg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic               step_pulse_o,
  input logic               direction_o,
  input logic signed [31:0] commanded_position_o,
  input logic signed [47:0] velocity_command_o
);

  // a waiting result stays put until it is popped
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable({step_pulse_o, direction_o,
                                             commanded_position_o, velocity_command_o})));

  // flags always known out of reset
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({full, empty}));

  // nothing to pop straight after reset
  a_empty_after_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty);

endmodule

bind stepper_pid_step_generator spsg_checker u_checker (.*);
